>>> hdl/ppc_pkg.sv
// Shared types, widths, codes and edge classification for the plane clipper.
`timescale 1ns / 1ps
package ppc_pkg;

   localparam int COORD_W   = 32;
   localparam int NORM_W    = 32;
   localparam int OFFS_W    = 32;
   localparam int TOL_W     = 16;
   localparam int FRAC_W    = 30;
   localparam int PROD_W    = 64;
   localparam int SUM_W     = PROD_W + 2;
   localparam int DIST_W    = SUM_W - FRAC_W;
   localparam int DEN_W     = DIST_W + 1;
   localparam int T_W       = FRAC_W + 1;
   localparam int NUM_W     = DIST_W + FRAC_W + 1;
   localparam int DELTA_W   = COORD_W + 1;
   localparam int LPROD_W   = DELTA_W + T_W;
   localparam int OFF_W     = LPROD_W - FRAC_W;
   localparam int STEP_W    = $clog2(T_W);

   localparam int MAX_VERTICES = 32;
   localparam int COUNT_W      = 7;
   localparam int COUNT_CAP    = (2 * MAX_VERTICES > 127) ? 127 : 2 * MAX_VERTICES;
   localparam int MIN_KEPT     = 3;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 3'd4;

   // job codes carried through the queue
   localparam logic [1:0] OP_Q   = 2'd0;   // emit the far end
   localparam logic [1:0] OP_I   = 2'd1;   // emit the intersection
   localparam logic [1:0] OP_IQ  = 2'd2;   // emit intersection, then far end
   localparam logic [1:0] OP_END = 2'd3;   // end-of-polygon marker

   typedef struct packed {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
      logic signed [OFFS_W-1:0] offset;
      logic [TOL_W-1:0]         tol;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                  op;
      logic [2:0][COORD_W-1:0]     p;
      logic [2:0][COORD_W-1:0]     q;
      logic [DIST_W-1:0]           a1;
      logic [DIST_W-1:0]           a2;
   } job_type;

   function automatic logic [DIST_W-1:0] dist_mag(input logic signed [DIST_W-1:0] d);
      return d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
   endfunction

   // true when the edge from d1 to d2 emits anything
   function automatic logic edge_keeps(input logic signed [DIST_W-1:0] d1,
                                       input logic signed [DIST_W-1:0] d2,
                                       input logic [TOL_W-1:0] tol);
      logic in1, in2, near1, near2;
      in1   = (d1 <= 0);
      in2   = (d2 <= 0);
      near1 = (dist_mag(d1) <= DIST_W'(tol));
      near2 = (dist_mag(d2) <= DIST_W'(tol));
      priority if ((in1 && in2) || (!in1 && near2)) return 1'b1;
      else if (near1 && !in2) return 1'b0;
      else return (in1 != in2);
   endfunction

   function automatic logic [1:0] edge_op(input logic signed [DIST_W-1:0] d1,
                                          input logic signed [DIST_W-1:0] d2,
                                          input logic [TOL_W-1:0] tol);
      logic in1, in2, near2;
      in1   = (d1 <= 0);
      in2   = (d2 <= 0);
      near2 = (dist_mag(d2) <= DIST_W'(tol));
      priority if ((in1 && in2) || (!in1 && near2)) return OP_Q;
      else if (in1) return OP_I;
      else return OP_IQ;
   endfunction

endpackage

>>> hdl/polygon_plane_clipper.sv
// Top level of the polygon plane clipper: configuration registers and the two ends.
`timescale 1ns / 1ps
// One clipping stage: clips a polygon against the configured plane.
// Request channel (req_*): one vertex per beat, req_final_vertex on the last.
//   A beat is taken when req_valid is high and req_stall low.
// Response channel (rsp_*): clipped vertices in order, then one end marker
//   beat (rsp_is_vertex low, rsp_last_of_run high) with the vertex count and
//   the collapsed flag. The receiver holds a beat by raising rsp_stall; the
//   result register keeps it and the back end waits, the front end keeps
//   taking vertices until the two-entry job queue fills.
// Configuration (csr_*): always ready; write only while the block is idle.
// Flow: the front end takes a vertex through multiply, sum and edge states,
//   and a final vertex also through the closing edge and end marker states;
//   it waits while the queue is full. The back end emits a kept far end
//   directly; for an intersection a restoring divider forms t one bit a
//   cycle, then one shared multiplier interpolates the three coordinates,
//   each in a multiply step and an add step.
// Reset (synchronous, active high): loads the default plane z = 0 with
//   tolerance 66, clears the queue, the polygon state and the response.
module polygon_plane_clipper import ppc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COORD_W-1:0]   req_vx,
   input  logic [COORD_W-1:0]   req_vy,
   input  logic [COORD_W-1:0]   req_vz,
   input  logic                 req_final_vertex,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COORD_W-1:0]   rsp_ox,
   output logic [COORD_W-1:0]   rsp_oy,
   output logic [COORD_W-1:0]   rsp_oz,
   output logic                 rsp_is_vertex,
   output logic                 rsp_last_of_run,
   output logic [COUNT_W-1:0]   rsp_vertex_count,
   output logic                 rsp_collapsed,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cfg_type cfg_ff;
   job_type push_job, pop_job;
   logic    push, pop, full, empty;

   assign csr_ready = 1'b1;

   // plane registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nx     <= '0;
         cfg_ff.ny     <= '0;
         cfg_ff.nz     <= NORM_W'(1) << FRAC_W;
         cfg_ff.offset <= '0;
         cfg_ff.tol    <= TOL_W'(66);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NORMAL_X:  cfg_ff.nx     <= csr_data;
            CSR_NORMAL_Y:  cfg_ff.ny     <= csr_data;
            CSR_NORMAL_Z:  cfg_ff.nz     <= csr_data;
            CSR_OFFSET:    cfg_ff.offset <= csr_data;
            CSR_TOLERANCE: cfg_ff.tol    <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   ppc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vx           (req_vx),
      .req_vy           (req_vy),
      .req_vz           (req_vz),
      .req_final_vertex (req_final_vertex),
      .cfg              (cfg_ff),
      .push             (push),
      .push_job         (push_job),
      .queue_full       (full)
   );

   ppc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   ppc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_job          (pop_job),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ox           (rsp_ox),
      .rsp_oy           (rsp_oy),
      .rsp_oz           (rsp_oz),
      .rsp_is_vertex    (rsp_is_vertex),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_collapsed    (rsp_collapsed)
   );

endmodule

>>> hdl/ppc_front.sv
// Front end: accepts vertices, computes plane distances and queues edge jobs.
`timescale 1ns / 1ps
module ppc_front import ppc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [COORD_W-1:0]  req_vx,
   input  logic [COORD_W-1:0]  req_vy,
   input  logic [COORD_W-1:0]  req_vz,
   input  logic                req_final_vertex,
   input  cfg_type             cfg,
   output logic                push,
   output job_type             push_job,
   input  logic                queue_full
);

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_MUL   = 3'd1;
   localparam logic [2:0] F_SUM   = 3'd2;
   localparam logic [2:0] F_EDGE1 = 3'd3;
   localparam logic [2:0] F_EDGE2 = 3'd4;
   localparam logic [2:0] F_END   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       have_first_ff, have_first_in;
   logic       final_ff;
   logic [2:0][COORD_W-1:0] vtx_ff, first_ff, prev_ff;
   logic signed [DIST_W-1:0] dist_ff, first_dist_ff, prev_dist_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [SUM_W-1:0]  sum;
   logic signed [DIST_W-1:0] dist_in;
   logic                     edge_push;

   assign req_stall = (state_ff != F_IDLE);

   // floor((sum of exact products + half) / 2^30) + offset
   always_comb begin
      sum = SUM_W'(px_ff) + SUM_W'(py_ff) + SUM_W'(pz_ff)
          + (SUM_W'(1) <<< (FRAC_W - 1));
      dist_in = DIST_W'(sum >>> FRAC_W) + DIST_W'(cfg.offset);
   end

   always_comb begin
      state_in      = state_ff;
      have_first_in = have_first_ff;
      push          = 1'b0;
      push_job      = '0;
      edge_push     = 1'b0;
      unique case (state_ff)
         F_IDLE: if (req_valid) state_in = F_MUL;
         F_MUL:  state_in = F_SUM;
         F_SUM:  state_in = F_EDGE1;
         F_EDGE1: begin
            push_job.op = edge_op(prev_dist_ff, dist_ff, cfg.tol);
            push_job.p  = prev_ff;
            push_job.q  = vtx_ff;
            push_job.a1 = dist_mag(prev_dist_ff);
            push_job.a2 = dist_mag(dist_ff);
            edge_push   = have_first_ff && edge_keeps(prev_dist_ff, dist_ff, cfg.tol);
            if (!(edge_push && queue_full)) begin
               push          = edge_push;
               have_first_in = 1'b1;
               state_in      = final_ff ? F_EDGE2 : F_IDLE;
            end
         end
         F_EDGE2: begin
            push_job.op = edge_op(dist_ff, first_dist_ff, cfg.tol);
            push_job.p  = vtx_ff;
            push_job.q  = first_ff;
            push_job.a1 = dist_mag(dist_ff);
            push_job.a2 = dist_mag(first_dist_ff);
            edge_push   = edge_keeps(dist_ff, first_dist_ff, cfg.tol);
            if (!(edge_push && queue_full)) begin
               push     = edge_push;
               state_in = F_END;
            end
         end
         F_END: begin
            push_job.op = OP_END;
            if (!queue_full) begin
               push          = 1'b1;
               have_first_in = 1'b0;
               state_in      = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         have_first_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_first_ff <= have_first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         vtx_ff   <= {req_vz, req_vy, req_vx};
         final_ff <= req_final_vertex;
      end
      if (state_ff == F_MUL) begin
         px_ff <= cfg.nx * $signed(vtx_ff[0]);
         py_ff <= cfg.ny * $signed(vtx_ff[1]);
         pz_ff <= cfg.nz * $signed(vtx_ff[2]);
      end
      if (state_ff == F_SUM) dist_ff <= dist_in;
      if (state_ff == F_EDGE1 && state_in != F_EDGE1) begin
         prev_ff      <= vtx_ff;
         prev_dist_ff <= dist_ff;
         if (!have_first_ff) begin
            first_ff      <= vtx_ff;
            first_dist_ff <= dist_ff;
         end
      end
   end

endmodule

>>> hdl/ppc_queue.sv
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
module ppc_queue import ppc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type    entry_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_job;
   end

endmodule

>>> hdl/ppc_back.sv
// Back end: runs edge jobs, divides and interpolates, and drives the result register.
`timescale 1ns / 1ps
module ppc_back import ppc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  job_type            pop_job,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COORD_W-1:0] rsp_ox,
   output logic [COORD_W-1:0] rsp_oy,
   output logic [COORD_W-1:0] rsp_oz,
   output logic               rsp_is_vertex,
   output logic               rsp_last_of_run,
   output logic [COUNT_W-1:0] rsp_vertex_count,
   output logic               rsp_collapsed
);

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_DIV   = 3'd1;
   localparam logic [2:0] B_MUL   = 3'd2;
   localparam logic [2:0] B_ADD   = 3'd3;
   localparam logic [2:0] B_EMITI = 3'd4;
   localparam logic [2:0] B_EMITQ = 3'd5;
   localparam logic [2:0] B_END   = 3'd6;

   logic [2:0]         state_ff, state_in;
   job_type            job_ff;
   logic [DEN_W-1:0]   den_ff, rem_ff;
   logic [T_W-1:0]     num_ff, quo_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [1:0]         idx_ff;
   logic [LPROD_W-1:0] prod_ff;
   logic               neg_ff;
   logic [2:0][COORD_W-1:0] res_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               out_valid_ff, out_free, emit;

   logic [DEN_W-1:0]   den_new;
   logic [NUM_W-1:0]   num_full;
   logic [DEN_W:0]     rem_shift;
   logic               qbit;
   logic signed [DELTA_W-1:0] delta;
   logic [DELTA_W-1:0] delta_mag;
   logic [LPROD_W-1:0] prod_rnd;
   logic [OFF_W-1:0]   off;
   logic [OFF_W-1:0]   lerp_sum;
   logic [COUNT_W-1:0] cnt_inc;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign pop       = (state_ff == B_IDLE) && !empty;
   assign emit      = out_free &&
                      (state_ff == B_EMITI || state_ff == B_EMITQ || state_ff == B_END);
   assign cnt_inc   = (cnt_ff < COUNT_W'(COUNT_CAP)) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      den_new   = DEN_W'(pop_job.a1) + DEN_W'(pop_job.a2);
      num_full  = (NUM_W'(pop_job.a1) << FRAC_W) + NUM_W'(den_new >> 1);
      rem_shift = {rem_ff, num_ff[T_W-1]};
      qbit      = (rem_shift >= {1'b0, den_ff});
      delta     = $signed({job_ff.q[idx_ff][COORD_W-1], job_ff.q[idx_ff]})
                - $signed({job_ff.p[idx_ff][COORD_W-1], job_ff.p[idx_ff]});
      delta_mag = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
      prod_rnd  = prod_ff + (LPROD_W'(1) << (FRAC_W - 1));
      off       = prod_rnd[LPROD_W-1:FRAC_W];
      lerp_sum  = neg_ff ? OFF_W'($signed(job_ff.p[idx_ff])) - off
                         : OFF_W'($signed(job_ff.p[idx_ff])) + off;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!empty) begin
            unique case (pop_job.op)
               OP_Q:    state_in = B_EMITQ;
               OP_END:  state_in = B_END;
               default: state_in = B_DIV;
            endcase
         end
         B_DIV:   if (step_ff == '0) state_in = B_MUL;
         B_MUL:   state_in = B_ADD;
         B_ADD:   state_in = (idx_ff == 2'd2) ? B_EMITI : B_MUL;
         B_EMITI: if (out_free) state_in = (job_ff.op == OP_IQ) ? B_EMITQ : B_IDLE;
         B_EMITQ: if (out_free) state_in = B_IDLE;
         B_END:   if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
         if (emit) cnt_ff <= (state_ff == B_END) ? '0 : cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            job_ff  <= pop_job;
            den_ff  <= den_new;
            rem_ff  <= DEN_W'(num_full[NUM_W-1:T_W]);
            num_ff  <= num_full[T_W-1:0];
            step_ff <= STEP_W'(T_W - 1);
            idx_ff  <= 2'd0;
         end
         B_DIV: begin
            rem_ff  <= qbit ? DEN_W'(rem_shift - {1'b0, den_ff}) : DEN_W'(rem_shift);
            num_ff  <= num_ff << 1;
            quo_ff  <= {quo_ff[T_W-2:0], qbit};
            step_ff <= step_ff - 1'b1;
         end
         B_MUL: begin
            prod_ff <= LPROD_W'(delta_mag) * LPROD_W'(quo_ff);
            neg_ff  <= delta[DELTA_W-1];
         end
         B_ADD: begin
            res_ff[idx_ff] <= lerp_sum[COORD_W-1:0];
            idx_ff         <= idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (emit) begin
         unique case (state_ff)
            B_EMITI: begin
               {rsp_oz, rsp_oy, rsp_ox} <= res_ff;
               rsp_is_vertex    <= 1'b1;
               rsp_last_of_run  <= 1'b0;
               rsp_vertex_count <= '0;
               rsp_collapsed    <= 1'b0;
            end
            B_EMITQ: begin
               {rsp_oz, rsp_oy, rsp_ox} <= job_ff.q;
               rsp_is_vertex    <= 1'b1;
               rsp_last_of_run  <= 1'b0;
               rsp_vertex_count <= '0;
               rsp_collapsed    <= 1'b0;
            end
            default: begin
               {rsp_oz, rsp_oy, rsp_ox} <= '0;
               rsp_is_vertex    <= 1'b0;
               rsp_last_of_run  <= 1'b1;
               rsp_vertex_count <= cnt_ff;
               rsp_collapsed    <= (cnt_ff < COUNT_W'(MIN_KEPT));
            end
         endcase
      end
   end

endmodule

>>> sim/polygon_plane_clipper_tb.sv
// Self-checking testbench for the polygon plane clipper stage.
`timescale 1ns / 1ps
module polygon_plane_clipper_tb;
   import ppc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [COORD_W-1:0]   req_vx = '0, req_vy = '0, req_vz = '0;
   logic                 req_final_vertex = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COORD_W-1:0]   rsp_ox, rsp_oy, rsp_oz;
   logic                 rsp_is_vertex, rsp_last_of_run, rsp_collapsed;
   logic [COUNT_W-1:0]   rsp_vertex_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NORMAL_X;
   logic [31:0]          csr_data = '0;

   polygon_plane_clipper dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one result beat as the block presents it
   typedef struct packed {
      logic [31:0] x, y, z;
      logic        is_vertex, last_of_run;
      logic [6:0]  count;
      logic        collapsed;
   } clip_out_type;

   // plane as the predictor sees it
   longint      pl_nx, pl_ny, pl_nz, pl_off;
   longint      pl_tol;
   // polygon state of the predictor
   longint      first_v[3], prev_v[3];
   longint      first_d, prev_d;
   bit          open_poly;
   int          kept_count;

   clip_out_type expected_beats[$];
   int          errors = 0;
   bit          stall_enable = 1'b1;
   int          stall_left = 0;

   // --- predictor -------------------------------------------------------

   function automatic longint fl30(longint p, output longint rem);
      longint q;
      q = p >>> 30;
      rem = p - (q <<< 30);
      return q;
   endfunction

   function automatic longint plane_distance(longint x, longint y, longint z);
      longint rx, ry, rz, q, rs;
      q = fl30(pl_nx * x, rx) + fl30(pl_ny * y, ry) + fl30(pl_nz * z, rz);
      rs = rx + ry + rz + (64'sd1 <<< 29);
      return q + (rs >>> 30) + pl_off;
   endfunction

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint interpolate(longint a, longint b, longint t);
      longint delta, off;
      delta = b - a;
      off = (magnitude(delta) * t + (64'sd1 <<< 29)) >>> 30;
      return delta < 0 ? a - off : a + off;
   endfunction

   function automatic void push_vertex(longint x, longint y, longint z);
      clip_out_type b;
      b = '0;
      b.x = x[31:0];
      b.y = y[31:0];
      b.z = z[31:0];
      b.is_vertex = 1'b1;
      expected_beats.push_back(b);
      if (kept_count < COUNT_CAP) kept_count++;
   endfunction

   function automatic void clip_edge(longint p[3], longint d1, longint q[3], longint d2);
      bit in1, in2, near1, near2;
      longint unsigned a1, den, t;
      in1 = d1 <= 0;
      in2 = d2 <= 0;
      near1 = magnitude(d1) <= pl_tol;
      near2 = magnitude(d2) <= pl_tol;
      if ((in1 && in2) || (!in1 && near2)) begin
         push_vertex(q[0], q[1], q[2]);
      end else if (near1 && !in2) begin
         // grazing exit: nothing kept
      end else if (in1 != in2) begin
         a1 = magnitude(d1);
         den = a1 + magnitude(d2);
         t = den != 0 ? ((a1 << 30) + den / 2) / den : 0;
         push_vertex(interpolate(p[0], q[0], t), interpolate(p[1], q[1], t),
                     interpolate(p[2], q[2], t));
         if (!in1) push_vertex(q[0], q[1], q[2]);
      end
   endfunction

   function automatic void predict_vertex(logic [31:0] x, y, z, logic fin);
      longint v[3], dv;
      clip_out_type b;
      v[0] = longint'($signed(x));
      v[1] = longint'($signed(y));
      v[2] = longint'($signed(z));
      dv = plane_distance(v[0], v[1], v[2]);
      if (!open_poly) begin
         first_v = v;
         first_d = dv;
         open_poly = 1'b1;
         kept_count = 0;
      end else begin
         clip_edge(prev_v, prev_d, v, dv);
      end
      prev_v = v;
      prev_d = dv;
      if (fin) begin
         clip_edge(prev_v, prev_d, first_v, first_d);
         b = '0;
         b.last_of_run = 1'b1;
         b.count = 7'(kept_count);
         b.collapsed = kept_count < MIN_KEPT;
         expected_beats.push_back(b);
         open_poly = 1'b0;
         kept_count = 0;
      end
   endfunction

   // --- drivers ---------------------------------------------------------

   function automatic int random_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   // valid stays high after a beat only when the next one follows at once
   task automatic send_vertex(logic [31:0] x, y, z, logic fin);
      int gap;
      gap = stall_enable ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vx <= x;
      req_vy <= y;
      req_vz <= z;
      req_final_vertex <= fin;
      // hold the beat until it is taken
      do @(posedge clock); while (req_stall);
      predict_vertex(x, y, z, fin);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NORMAL_X:  pl_nx = longint'($signed(value));
         CSR_NORMAL_Y:  pl_ny = longint'($signed(value));
         CSR_NORMAL_Z:  pl_nz = longint'($signed(value));
         CSR_OFFSET:    pl_off = longint'($signed(value));
         CSR_TOLERANCE: pl_tol = longint'(value[15:0]);
         default: ;
      endcase
   endtask

   // drop the request, drain all pending results, then let the back end settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_plane(logic [31:0] nx, ny, nz, off, logic [15:0] tol);
      wait_idle();
      write_csr(CSR_NORMAL_X, nx);
      write_csr(CSR_NORMAL_Y, ny);
      write_csr(CSR_NORMAL_Z, nz);
      write_csr(CSR_OFFSET, off);
      write_csr(CSR_TOLERANCE, {16'h0, tol});
      csr_valid <= 1'b0;
   endtask

   // --- result checker --------------------------------------------------

   always @(posedge clock) begin
      clip_out_type got, exp_b;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_ox, rsp_oy, rsp_oz, rsp_is_vertex, rsp_last_of_run,
                rsp_vertex_count, rsp_collapsed};
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
         end else begin
            exp_b = expected_beats.pop_front();
            if (got.x !== exp_b.x)
               $display("%0t: ox expected %h actual %h", $time, exp_b.x, got.x);
            if (got.y !== exp_b.y)
               $display("%0t: oy expected %h actual %h", $time, exp_b.y, got.y);
            if (got.z !== exp_b.z)
               $display("%0t: oz expected %h actual %h", $time, exp_b.z, got.z);
            if (got.is_vertex !== exp_b.is_vertex)
               $display("%0t: is_vertex expected %b actual %b", $time,
                        exp_b.is_vertex, got.is_vertex);
            if (got.last_of_run !== exp_b.last_of_run)
               $display("%0t: last_of_run expected %b actual %b", $time,
                        exp_b.last_of_run, got.last_of_run);
            if (got.count !== exp_b.count)
               $display("%0t: vertex_count expected %0d actual %0d", $time,
                        exp_b.count, got.count);
            if (got.collapsed !== exp_b.collapsed)
               $display("%0t: collapsed expected %b actual %b", $time,
                        exp_b.collapsed, got.collapsed);
            if (got !== exp_b) errors++;
         end
      end
   end

   // receiver back-pressure: random stall stretches, most short, a few long
   always @(posedge clock) begin
      if (reset || !stall_enable) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = random_gap();
         rsp_stall <= stall_left > 0;
         if (stall_left > 0) stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // --- tests -----------------------------------------------------------

   // random coordinate, mostly modest with occasional full range
   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 15) == 0) return $urandom();
      return 32'($signed($urandom_range(0, 32'h00c8_0000)) - 32'sh0064_0000);
   endfunction

   task automatic test_directed_polygons();
      // default plane z = 0: square straddling it
      send_vertex(32'h0001_0000, 32'h0, 32'hffff_0000, 1'b0);
      send_vertex(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
      send_vertex(32'hffff_0000, 32'h0, 32'h0001_0000, 1'b0);
      send_vertex(32'hffff_0000, 32'h0, 32'hffff_0000, 1'b1);
      // single vertex polygon, inside then outside
      send_vertex(32'h0, 32'h0, 32'hffff_0000, 1'b1);
      send_vertex(32'h0, 32'h0, 32'h0005_0000, 1'b1);
      // near-plane vertices against outside ones
      send_vertex(32'h0, 32'h0, 32'h0000_0020, 1'b0);
      send_vertex(32'h0, 32'h0003_0000, 32'h0002_0000, 1'b0);
      send_vertex(32'h0001_0000, 32'h0, 32'hffff_ffe0, 1'b1);
      // coordinate extremes
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
      send_vertex(32'hffff_ffff, 32'h0, 32'h8000_0001, 1'b1);
      // two-vertex polygon collapses
      send_vertex(32'h0, 32'h0, 32'hffff_0000, 1'b0);
      send_vertex(32'h0001_0000, 32'h0, 32'hfffe_0000, 1'b1);
   endtask

   task automatic test_long_polygon();
      int i;
      // all inside: count saturates beyond the cap
      for (i = 0; i < 70; i++)
         send_vertex(rand_coord(), rand_coord(), 32'hfff0_0000 | $urandom_range(0, 16'hffff),
                     i == 69);
   endtask

   task automatic test_random_polygons(int n_items);
      int sent, len, i;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         for (i = 0; i < len; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
         sent += len;
      end
   endtask

   initial begin
      pl_nx = 0; pl_ny = 0; pl_nz = 64'sd1 <<< 30; pl_off = 0; pl_tol = 66;
      open_poly = 1'b0;
      kept_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_polygons();
      test_long_polygon();
      // extreme planes: negative unit normals, offset limits, tolerance bounds
      set_plane(32'hc000_0000, 32'h0, 32'h0, 32'h7fff_ffff, 16'hffff);
      test_random_polygons(40);
      set_plane(32'h0, 32'h4000_0000, 32'h0, 32'h8000_0000, 16'h0);
      test_random_polygons(40);
      set_plane(32'h2000_0000, 32'hd000_0000, 32'h2d41_3ccd, 32'h0002_8000, 16'h0100);
      test_random_polygons(120);
      set_plane(32'h0, 32'h0, 32'hc000_0000, 32'hfff0_0000, 16'h0042);
      stall_enable = 1'b0;
      test_random_polygons(30);
      stall_enable = 1'b1;
      set_plane($urandom_range(0, 32'h4000_0000), 32'h0 - $urandom_range(0, 32'h4000_0000),
                $urandom_range(0, 32'h4000_0000), $urandom(), 16'($urandom()));
      test_random_polygons(50);

      wait_idle();
      if (errors == 0)
         $display("polygon_plane_clipper_tb: PASS");
      else
         $display("polygon_plane_clipper_tb: FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("polygon_plane_clipper_tb: FAIL");
      $finish;
   end

endmodule

>>> polygon_plane_clipper.f
hdl/ppc_pkg.sv
hdl/ppc_front.sv
hdl/ppc_queue.sv
hdl/ppc_back.sv
hdl/polygon_plane_clipper.sv
sim/polygon_plane_clipper_tb.sv
